// ===== design/olgen_pkg.sv =====
// shared types, codes and font table for the oled text byte stream generator
// no dependencies; imported by every module of the block
package olgen_pkg;

    // operation codes of an input request
    localparam logic OP_PRINT = 1'b0;
    localparam logic OP_MOVE  = 1'b1;

    // special characters and bus constants
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CTRL_CMD       = 8'h00;
    localparam logic [7:0] CTRL_DATA      = 8'h40;
    localparam logic [7:0] SPACER_COLUMN  = 8'h00;
    localparam logic [3:0] CMD_PAGE_HI    = 4'hB;
    localparam logic [3:0] CMD_COL_LO_HI  = 4'h0;
    localparam logic [3:0] CMD_COL_HI_HI  = 4'h1;
    localparam logic [6:0] DEV_ADDR_RESET = 7'd60;

    // font size
    localparam int unsigned GLYPH_COUNT = 22;
    localparam int unsigned GLYPH_COLS  = 5;

    // input request as seen on the slave channel
    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
        logic [2:0] text_row;
        logic [7:0] text_column;
    } in_item_t;

    // one bus byte as seen on the master channel
    typedef struct packed {
        logic [7:0] bus_byte;
        logic       start_before;
        logic       stop_after;
        logic       last_of_run;
    } out_item_t;

    // classified job passed from front to back
    typedef struct packed {
        logic       is_cmd;
        logic [4:0] glyph;
        logic [2:0] page;
        logic [7:0] column;
    } job_t;

    // glyph columns, first column in the top byte
    localparam logic [39:0] GLYPHS [GLYPH_COUNT] = '{
        40'h00_00_00_00_00,  // space and unknown
        40'h00_60_60_00_00,  // .
        40'h08_08_08_08_08,  // -
        40'h3E_51_49_45_3E,  // 0
        40'h00_42_7F_40_00,  // 1
        40'h62_51_49_49_46,  // 2
        40'h22_49_49_49_36,  // 3
        40'h18_14_12_7F_10,  // 4
        40'h2F_49_49_49_31,  // 5
        40'h3E_49_49_49_32,  // 6
        40'h01_71_09_05_03,  // 7
        40'h36_49_49_49_36,  // 8
        40'h26_49_49_49_3E,  // 9
        40'h00_36_36_00_00,  // :
        40'h3E_41_41_41_22,  // C
        40'h7F_09_09_09_06,  // P
        40'h01_01_7F_01_01,  // T
        40'h20_54_54_54_78,  // a
        40'h38_54_54_54_18,  // e
        40'h7F_08_04_04_78,  // h
        40'h7C_04_18_04_78,  // m
        40'h7C_14_14_14_08   // p
    };

    // character code to glyph number, blank for anything not in the font
    function automatic logic [4:0] glyph_index(input logic [7:0] ch);
        logic [4:0] idx;
        idx = 5'd0;
        if (ch >= "0" && ch <= "9") begin
            idx = 5'd3 + 5'(ch - "0");
        end else begin
            case (ch)
                ".":     idx = 5'd1;
                "-":     idx = 5'd2;
                ":":     idx = 5'd13;
                "C":     idx = 5'd14;
                "P":     idx = 5'd15;
                "T":     idx = 5'd16;
                "a":     idx = 5'd17;
                "e":     idx = 5'd18;
                "h":     idx = 5'd19;
                "m":     idx = 5'd20;
                "p":     idx = 5'd21;
                default: idx = 5'd0;
            endcase
        end
        return idx;
    endfunction

    // one column byte of a glyph
    function automatic logic [7:0] glyph_col(input logic [4:0] idx, input logic [2:0] col);
        logic [39:0] row;
        logic [7:0]  res;
        row = '0;
        res = '0;
        if (32'(idx) < GLYPH_COUNT) begin
            row = GLYPHS[idx];
        end
        if (32'(col) < GLYPH_COLS) begin
            res = row[(GLYPH_COLS - 1 - 32'(col)) * 8 +: 8];
        end
        return res;
    endfunction

endpackage

// ===== design/oled_text_byte_stream_generator_top.sv =====
// top level of the oled text byte stream generator
// depends on olgen_pkg, olgen_front, olgen_queue and olgen_back
// path: a taken request passes the job queue and the job register; its bus bytes leave from the output register
// throughput: one bus byte a cycle unless m_ready stalls; a print is 8 bus bytes, a newline
//   or move 9, set by the byte sequencer in the back end; a job queue lets requests arrive early
// reset: synchronous on aresetn low; cursor page to 0, device address to 60, queue empty
module oled_text_byte_stream_generator_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wen,
    input  logic [6:0]             cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  olgen_pkg::in_item_t    s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output olgen_pkg::out_item_t   m_item
);
    import olgen_pkg::*;

    logic [6:0] device_address_reg;
    logic       q_full;
    logic       q_push;
    job_t       q_push_job;
    logic       q_pop;
    logic       q_valid;
    job_t       q_head_job;

    // device address register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= DEV_ADDR_RESET;
        end else if (cfg_wen) begin
            device_address_reg <= cfg_wdata;
        end
    end

    olgen_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (q_push_job)
    );

    olgen_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head_job)
    );

    olgen_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .device_address (device_address_reg),
        .q_valid        (q_valid),
        .q_job          (q_head_job),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item)
    );

endmodule

// ===== design/olgen_front.sv =====
// front end: accepts requests, classifies them and tracks the cursor page
// depends on olgen_pkg
module olgen_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  olgen_pkg::in_item_t s_item,
    input  logic              q_full,
    output logic              q_push,
    output olgen_pkg::job_t   q_job
);
    import olgen_pkg::*;

    logic [2:0] current_page_reg;
    logic [2:0] current_page_next;
    logic [7:0] pixel_col;
    logic       take;

    assign s_ready = !q_full;
    assign take    = s_valid && !q_full;
    assign q_push  = take;

    // character column times six, kept to eight bits
    assign pixel_col = {s_item.text_column[6:0], 1'b0} + {s_item.text_column[5:0], 2'b00};

    // classify the request
    always_comb begin
        q_job             = '0;
        current_page_next = current_page_reg;
        if (s_item.operation == OP_MOVE) begin
            q_job.is_cmd      = 1'b1;
            q_job.page        = s_item.text_row;
            q_job.column      = pixel_col;
            current_page_next = s_item.text_row;
        end else if (s_item.char_code == CHAR_NEWLINE) begin
            q_job.is_cmd      = 1'b1;
            q_job.page        = current_page_reg + 3'd1;
            q_job.column      = 8'd0;
            current_page_next = current_page_reg + 3'd1;
        end else begin
            q_job.glyph = glyph_index(s_item.char_code);
        end
    end

    // cursor page
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_page_reg <= 3'd0;
        end else if (take) begin
            current_page_reg <= current_page_next;
        end
    end

endmodule

// ===== design/olgen_queue.sv =====
// short job queue between front and back ends
// depends on olgen_pkg
module olgen_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  olgen_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output olgen_pkg::job_t head_job
);
    import olgen_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    job_t          slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/olgen_back.sv =====
// back end: steps through the bus bytes of one job, one byte per cycle unless m_ready stalls the output
// depends on olgen_pkg
module olgen_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [6:0]        device_address,
    input  logic              q_valid,
    input  olgen_pkg::job_t   q_job,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output olgen_pkg::out_item_t m_item
);
    import olgen_pkg::*;

    // byte positions inside a job
    localparam logic [3:0] STEP_ADDR0     = 4'd0;
    localparam logic [3:0] STEP_CTRL0     = 4'd1;
    localparam logic [3:0] STEP_CMD0      = 4'd2;
    localparam logic [3:0] STEP_ADDR1     = 4'd3;
    localparam logic [3:0] STEP_CTRL1     = 4'd4;
    localparam logic [3:0] STEP_CMD1      = 4'd5;
    localparam logic [3:0] STEP_ADDR2     = 4'd6;
    localparam logic [3:0] STEP_CTRL2     = 4'd7;
    localparam logic [3:0] STEP_CMD2      = 4'd8;
    localparam logic [3:0] STEP_GLYPH0    = 4'd2;
    localparam logic [3:0] STEP_GLYPH4    = 4'd6;
    localparam logic [3:0] STEP_SPACER    = 4'd7;

    job_t      job_reg;
    logic [3:0] step_reg;
    logic      busy_reg;
    logic      m_valid_reg;
    out_item_t m_item_reg;
    out_item_t byte_next;
    logic      advance;
    logic      last_step;
    logic      load;
    logic [7:0] addr_byte;
    logic [2:0] glyph_pos;

    assign addr_byte = {device_address, 1'b0};
    assign glyph_pos = step_reg[2:0] - 3'd2;
    assign advance   = busy_reg && (!m_valid_reg || m_ready);
    assign last_step = job_reg.is_cmd ? (step_reg == STEP_CMD2) : (step_reg == STEP_SPACER);
    assign load      = q_valid && (!busy_reg || (advance && last_step));
    assign q_pop     = load;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // byte for the current step
    always_comb begin
        byte_next             = '0;
        byte_next.last_of_run = last_step;
        if (job_reg.is_cmd) begin
            case (step_reg)
                STEP_ADDR0, STEP_ADDR1, STEP_ADDR2: begin
                    byte_next.bus_byte     = addr_byte;
                    byte_next.start_before = 1'b1;
                end
                STEP_CTRL0, STEP_CTRL1, STEP_CTRL2: begin
                    byte_next.bus_byte = CTRL_CMD;
                end
                STEP_CMD0: begin
                    byte_next.bus_byte   = {CMD_PAGE_HI, 1'b0, job_reg.page};
                    byte_next.stop_after = 1'b1;
                end
                STEP_CMD1: begin
                    byte_next.bus_byte   = {CMD_COL_LO_HI, job_reg.column[3:0]};
                    byte_next.stop_after = 1'b1;
                end
                STEP_CMD2: begin
                    byte_next.bus_byte   = {CMD_COL_HI_HI, job_reg.column[7:4]};
                    byte_next.stop_after = 1'b1;
                end
                default: begin
                    byte_next.bus_byte = CTRL_CMD;
                end
            endcase
        end else begin
            priority if (step_reg == STEP_ADDR0) begin
                byte_next.bus_byte     = addr_byte;
                byte_next.start_before = 1'b1;
            end else if (step_reg == STEP_CTRL0) begin
                byte_next.bus_byte = CTRL_DATA;
            end else if (step_reg >= STEP_GLYPH0 && step_reg <= STEP_GLYPH4) begin
                byte_next.bus_byte = glyph_col(job_reg.glyph, glyph_pos);
            end else begin
                byte_next.bus_byte   = SPACER_COLUMN;
                byte_next.stop_after = 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_item_reg <= byte_next;
        end
    end

    // job register and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 4'd0;
        end else if (load) begin
            busy_reg <= 1'b1;
            step_reg <= 4'd0;
        end else if (advance) begin
            step_reg <= step_reg + 4'd1;
            if (last_step) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= q_job;
        end
    end

endmodule

// ===== design/olgen_checker.sv =====
// port level checks for the oled text byte stream generator, bound to the top
// depends on olgen_pkg and oled_text_byte_stream_generator_top
module olgen_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input olgen_pkg::out_item_t m_item
);
    import olgen_pkg::*;

    // output channel empty after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an address byte opens a transaction and never closes it
    a_start_not_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.start_before |-> !m_item.stop_after && !m_item.last_of_run)
        else $error("start byte marked as stop or last");

    // the final byte of a request always ends a transaction
    a_last_is_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.last_of_run |-> m_item.stop_after)
        else $error("last byte without stop");

    // a transaction ending mid-request is followed at once by a new start
    a_next_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_item.stop_after && !m_item.last_of_run
        |=> m_valid && m_item.start_before)
        else $error("missing start after mid-request stop");

    // stalled bus byte holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result dropped or changed while stalled");

endmodule

bind oled_text_byte_stream_generator_top olgen_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// ===== tb/tb_oled_text_byte_stream_generator_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the oled text byte stream generator
// depends on olgen_pkg and oled_text_byte_stream_generator_top
module tb_oled_text_byte_stream_generator_top;
    import olgen_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES   = 160;

    // expected bus bytes, with a private copy of cursor page and device address
    class bus_byte_scoreboard;
        out_item_t   expected_bytes[$];
        logic [6:0]  dev_addr;
        logic [2:0]  cursor_page;
        int unsigned failures;
        int unsigned bytes_seen;

        function new();
            dev_addr    = DEV_ADDR_RESET;
            cursor_page = 3'd0;
            failures    = 0;
            bytes_seen  = 0;
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        // five font columns, first column in the top byte; blank for unknown codes
        function logic [39:0] font_columns(logic [7:0] ch);
            case (ch)
                8'h2E:   return 40'h00_60_60_00_00;
                8'h2D:   return 40'h08_08_08_08_08;
                8'h30:   return 40'h3E_51_49_45_3E;
                8'h31:   return 40'h00_42_7F_40_00;
                8'h32:   return 40'h62_51_49_49_46;
                8'h33:   return 40'h22_49_49_49_36;
                8'h34:   return 40'h18_14_12_7F_10;
                8'h35:   return 40'h2F_49_49_49_31;
                8'h36:   return 40'h3E_49_49_49_32;
                8'h37:   return 40'h01_71_09_05_03;
                8'h38:   return 40'h36_49_49_49_36;
                8'h39:   return 40'h26_49_49_49_3E;
                8'h3A:   return 40'h00_36_36_00_00;
                8'h43:   return 40'h3E_41_41_41_22;
                8'h50:   return 40'h7F_09_09_09_06;
                8'h54:   return 40'h01_01_7F_01_01;
                8'h61:   return 40'h20_54_54_54_78;
                8'h65:   return 40'h38_54_54_54_18;
                8'h68:   return 40'h7F_08_04_04_78;
                8'h6D:   return 40'h7C_04_18_04_78;
                8'h70:   return 40'h7C_14_14_14_08;
                default: return 40'h00_00_00_00_00;
            endcase
        endfunction

        function void push_byte(logic [7:0] b, logic start, logic stop);
            out_item_t e;
            e.bus_byte     = b;
            e.start_before = start;
            e.stop_after   = stop;
            e.last_of_run  = 1'b0;
            expected_bytes.push_back(e);
        endfunction

        // one command transaction: address, command control byte, command
        function void push_command(logic [7:0] cmd);
            push_byte({dev_addr, 1'b0}, 1'b1, 1'b0);
            push_byte(CTRL_CMD, 1'b0, 1'b0);
            push_byte(cmd, 1'b0, 1'b1);
        endfunction

        function void place_cursor(logic [2:0] page, logic [7:0] col);
            cursor_page = page;
            push_command({CMD_PAGE_HI, 1'b0, page});
            push_command({CMD_COL_LO_HI, col[3:0]});
            push_command({CMD_COL_HI_HI, col[7:4]});
        endfunction

        // accepted request: work out every bus byte it causes
        function void note_request(in_item_t r);
            logic [39:0] cols;
            out_item_t   tail;
            if (r.operation == OP_MOVE) begin
                place_cursor(r.text_row, 8'(r.text_column * 6));
            end else if (r.char_code == CHAR_NEWLINE) begin
                place_cursor(cursor_page + 3'd1, 8'd0);
            end else begin
                cols = font_columns(r.char_code);
                push_byte({dev_addr, 1'b0}, 1'b1, 1'b0);
                push_byte(CTRL_DATA, 1'b0, 1'b0);
                for (int i = 0; i < 5; i++) begin
                    push_byte(cols[(4 - i) * 8 +: 8], 1'b0, 1'b0);
                end
                push_byte(SPACER_COLUMN, 1'b0, 1'b1);
            end
            tail = expected_bytes.pop_back();
            tail.last_of_run = 1'b1;
            expected_bytes.push_back(tail);
        endfunction

        // compare one bus byte with the oldest expectation
        function void check_byte(out_item_t got);
            out_item_t want;
            if (expected_bytes.size() == 0) begin
                if (failures < 10) begin
                    $display("byte %0d unexpected: byte %h start %b stop %b last %b",
                             bytes_seen, got.bus_byte, got.start_before,
                             got.stop_after, got.last_of_run);
                end
                failures++;
            end else begin
                want = expected_bytes.pop_front();
                if (got.bus_byte !== want.bus_byte || got.start_before !== want.start_before ||
                    got.stop_after !== want.stop_after ||
                    got.last_of_run !== want.last_of_run) begin
                    if (failures < 10) begin
                        $display("byte %0d mismatch: expected %h %b %b %b, got %h %b %b %b",
                                 bytes_seen, want.bus_byte, want.start_before,
                                 want.stop_after, want.last_of_run, got.bus_byte,
                                 got.start_before, got.stop_after, got.last_of_run);
                    end
                    failures++;
                end
            end
            bytes_seen++;
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      cfg_wen;
    logic [6:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    bus_byte_scoreboard byte_board = new();

    // idling controls shared by the driving processes
    bit tx_idle       = 1'b1;
    bit rx_idle       = 1'b1;
    bit long_hold_req = 1'b0;

    oled_text_byte_stream_generator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // 50 MHz clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // watch both channels at each edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                byte_board.note_request(s_item);
            end
            if (m_valid && m_ready) begin
                byte_board.check_byte(m_item);
            end
        end
    end

    // receiver: random stall bursts, and one long hold on request
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // run time guard
    initial begin
        #5_000_000;
        $display("tb_oled_text_byte_stream_generator_top: errors");
        $finish;
    end

    function automatic in_item_t make_request(logic op, logic [7:0] ch, logic [2:0] row,
                                              logic [7:0] col);
        in_item_t r;
        r.operation   = op;
        r.char_code   = ch;
        r.text_row    = row;
        r.text_column = col;
        return r;
    endfunction

    // mostly font characters, some newlines, moves and arbitrary codes
    function automatic in_item_t random_request();
        in_item_t    r;
        int unsigned pick;
        string       font_set;
        font_set = " .-0123456789:CPTaehmp";
        r = make_request(OP_PRINT, 8'($urandom), 3'($urandom), 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            r.char_code = font_set[$urandom_range(0, font_set.len() - 1)];
        end else if (pick >= 62 && pick < 78) begin
            r.char_code = CHAR_NEWLINE;
        end else if (pick >= 78) begin
            r.operation = OP_MOVE;
        end
        return r;
    endfunction

    // offer one request, optionally after a gap, and wait until it is taken
    task automatic send_request(input in_item_t r);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering and wait for every outstanding byte
    task automatic drain_results();
        s_valid <= 1'b0;
        // let the monitor note the request taken at this edge first
        @(posedge aclk);
        while (byte_board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_address(input logic [6:0] a);
        cfg_wen   <= 1'b1;
        cfg_wdata <= a;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        byte_board.dev_addr = a;
    endtask

    // random requests, idling switched on and off in stretches
    task automatic run_random(input int unsigned count, input bit allow_idle);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 16 == 0) begin
                tx_idle = allow_idle && ($urandom_range(0, 3) != 0);
                rx_idle = allow_idle && ($urandom_range(0, 3) != 0);
            end
            send_request(random_request());
        end
    endtask

    initial begin
        logic [7:0] print_codes[16];
        print_codes = '{8'h00, 8'hFF, 8'h20, 8'h2E, 8'h2D, 8'h30, 8'h39, 8'h3A,
                        8'h43, 8'h50, 8'h54, 8'h61, 8'h65, 8'h68, 8'h6D, 8'h70};
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_item    = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset address, code extremes, every glyph class
        foreach (print_codes[i]) begin
            send_request(make_request(OP_PRINT, print_codes[i], 3'd0, 8'd0));
        end
        // codes just outside the digit and colon range print blank
        send_request(make_request(OP_PRINT, 8'h2F, 3'd7, 8'hFF));
        send_request(make_request(OP_PRINT, 8'h3B, 3'd0, 8'd0));
        // move to last row and widest column, then newline wraps to page 0
        send_request(make_request(OP_MOVE, 8'hFF, 3'd7, 8'hFF));
        send_request(make_request(OP_PRINT, CHAR_NEWLINE, 3'd7, 8'hFF));
        send_request(make_request(OP_PRINT, CHAR_NEWLINE, 3'd0, 8'd0));
        // move ignores a newline code; pixel column overflow past 255
        send_request(make_request(OP_MOVE, CHAR_NEWLINE, 3'd0, 8'd0));
        send_request(make_request(OP_MOVE, 8'h00, 3'd5, 8'd43));
        send_request(make_request(OP_MOVE, 8'h41, 3'd2, 8'd42));
        drain_results();

        // top address; receiver holds off while requests keep coming
        write_address(7'h7F);
        tx_idle = 1'b0;
        long_hold_req = 1'b1;
        repeat (10) send_request(random_request());
        run_random(45, 1'b1);
        drain_results();

        // zero address; sender pauses midway until all bytes are out
        write_address(7'h00);
        run_random(27, 1'b1);
        drain_results();
        run_random(28, 1'b1);
        drain_results();

        write_address(7'($urandom_range(1, 126)));
        run_random(55, 1'b1);
        drain_results();

        // last part at full rate, no idling
        write_address(7'h55);
        run_random(45, 1'b0);
        drain_results();

        if (byte_board.failures == 0 && byte_board.pending() == 0) begin
            $display("tb_oled_text_byte_stream_generator_top: clean");
        end else begin
            $display("tb_oled_text_byte_stream_generator_top: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/olgen_pkg.sv
design/olgen_front.sv
design/olgen_queue.sv
design/olgen_back.sv
design/oled_text_byte_stream_generator_top.sv
design/olgen_checker.sv
tb/tb_oled_text_byte_stream_generator_top.sv
